// File: src/lcdw_pkg.sv
package lcdw_pkg;

	// Input request fields
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
		logic [5:0] column;
		logic       line;
	} in_t;

	// One pin state of the LCD bus
	typedef struct packed {
		logic        rs_pin;
		logic        enable_pin;
		logic [3:0]  data_nibble;
		logic        drive_on;
		logic [13:0] hold_us;
		logic        last;
	} out_t;

	// Operation codes
	localparam logic [2:0] CMD_INIT  = 3'd0;
	localparam logic [2:0] CMD_INSTR = 3'd1;
	localparam logic [2:0] CMD_DATA  = 3'd2;
	localparam logic [2:0] CMD_POS   = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;
	localparam logic [2:0] CMD_OFF   = 3'd5;

	// Kind of pin state to build
	localparam logic [1:0] KIND_POWER   = 2'd0;
	localparam logic [1:0] KIND_STROBE  = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// Extra wait codes added to an E-low hold
	localparam logic [2:0] WAIT_NONE = 3'd0;
	localparam logic [2:0] WAIT_4000 = 3'd1;
	localparam logic [2:0] WAIT_100  = 3'd2;
	localparam logic [2:0] WAIT_1000 = 3'd3;
	localparam logic [2:0] WAIT_2000 = 3'd4;

	localparam logic [13:0] POWER_HOLD_US = 14'd15000;
	localparam logic [9:0]  STROBE_RESET  = 10'd50;

	// Power-up bytes and fixed instructions
	localparam logic [3:0] NIB_WAKE     = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT = 4'h2;
	localparam logic [7:0] BYTE_FUNC    = 8'h28;
	localparam logic [7:0] BYTE_DISP_ON = 8'h0C;
	localparam logic [7:0] BYTE_ENTRY   = 8'h06;
	localparam logic [7:0] BYTE_CLEAR   = 8'h01;
	localparam logic [7:0] BYTE_DISP_OFF = 8'h08;

	// Controller to datapath command
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] kind;
		logic       enable;
		logic       use_item;
		logic       hi;
		logic [3:0] nib;
		logic [2:0] wait_sel;
		logic       last;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [13:0] wait_us(input logic [2:0] sel);
		logic [13:0] w;
		case (sel)
			WAIT_4000: w = 14'd4000;
			WAIT_100:  w = 14'd100;
			WAIT_1000: w = 14'd1000;
			WAIT_2000: w = 14'd2000;
			default:   w = 14'd0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = BYTE_FUNC;
			2'd1:    b = BYTE_DISP_ON;
			2'd2:    b = BYTE_ENTRY;
			default: b = BYTE_CLEAR;
		endcase
		return b;
	endfunction

endpackage

// File: src/lcdw_ctrl.sv
module lcdw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [2:0]       in_cmd,
	output logic             in_stall,
	input  lcdw_pkg::sts_t   sts,
	output lcdw_pkg::ctl_t   ctl
);
	import lcdw_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic       state_q;
	logic [2:0] cmd_q;
	logic [4:0] step_q;
	logic [4:0] last_step;
	logic [2:0] wake_k;
	logic [3:0] byte_k;
	logic [7:0] ib;
	logic       accept;
	logic       cmd_ok;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign cmd_ok   = in_cmd inside {[CMD_INIT:CMD_OFF]};

	assign wake_k = 3'(step_q - 5'd1);
	assign byte_k = 4'(step_q - 5'd9);
	assign ib     = init_byte(byte_k[3:2]);

	// Pick the last step index of the held operation
	always_comb begin
		case (cmd_q)
			CMD_INIT: last_step = 5'd24;
			CMD_OFF:  last_step = 5'd4;
			default:  last_step = 5'd3;
		endcase
	end

	// Decode the current step into a datapath command
	always_comb begin
		ctl          = '0;
		ctl.load     = accept;
		ctl.emit     = (state_q == ST_RUN) && sts.out_free;
		ctl.kind     = KIND_STROBE;
		ctl.last     = (step_q == last_step);
		ctl.wait_sel = WAIT_NONE;
		if (cmd_q == CMD_INIT) begin
			if (step_q == 5'd0) begin
				ctl.kind = KIND_POWER;
			end else if (step_q < 5'd9) begin
				ctl.enable = ~wake_k[0];
				ctl.nib    = (wake_k[2:1] == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
				if (wake_k[0]) begin
					case (wake_k[2:1])
						2'd0:    ctl.wait_sel = WAIT_4000;
						2'd1:    ctl.wait_sel = WAIT_100;
						default: ctl.wait_sel = WAIT_1000;
					endcase
				end
			end else begin
				ctl.enable = ~byte_k[0];
				ctl.nib    = byte_k[1] ? ib[3:0] : ib[7:4];
				if (byte_k == 4'd15)
					ctl.wait_sel = WAIT_2000;
			end
		end else if (cmd_q == CMD_OFF && step_q == 5'd4) begin
			ctl.kind = KIND_RELEASE;
		end else begin
			ctl.use_item = 1'b1;
			ctl.hi       = ~step_q[1];
			ctl.enable   = ~step_q[0];
			if (cmd_q == CMD_CLEAR && step_q == 5'd3)
				ctl.wait_sel = WAIT_2000;
		end
	end

	// Advance through the steps of one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_INIT;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd_ok) begin
						state_q <= ST_RUN;
						cmd_q   <= in_cmd;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (ctl.emit) begin
						if (ctl.last)
							state_q <= ST_IDLE;
						step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/lcdw_dpath.sv
module lcdw_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  lcdw_pkg::in_t    in_data,
	input  lcdw_pkg::ctl_t   ctl,
	output lcdw_pkg::sts_t   sts,
	input  logic             cfg_we,
	input  logic [9:0]       cfg_wdata,
	output logic             out_valid,
	input  logic             out_stall,
	output lcdw_pkg::out_t   out_data
);
	import lcdw_pkg::*;

	logic [9:0] strobe_q;
	logic       lines_q;
	logic [7:0] byte_q;
	logic       rs_q;
	logic       out_valid_q;
	out_t       out_q;
	out_t       res;
	logic [7:0] item_byte;

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// Form the byte an operation sends
	always_comb begin
		case (in_data.cmd)
			CMD_POS:   item_byte = {1'b1, in_data.line, in_data.column};
			CMD_CLEAR: item_byte = BYTE_CLEAR;
			CMD_OFF:   item_byte = BYTE_DISP_OFF;
			default:   item_byte = in_data.value;
		endcase
	end

	// Build the next pin state
	always_comb begin
		res = '0;
		res.last = ctl.last;
		case (ctl.kind)
			KIND_POWER: begin
				res.drive_on = 1'b1;
				res.hold_us  = POWER_HOLD_US;
			end
			KIND_STROBE: begin
				res.rs_pin      = ctl.use_item ? rs_q : 1'b0;
				res.enable_pin  = ctl.enable;
				res.data_nibble = !ctl.use_item ? ctl.nib :
					(ctl.hi ? byte_q[7:4] : byte_q[3:0]);
				res.drive_on    = lines_q;
				res.hold_us     = {4'b0, strobe_q} + wait_us(ctl.wait_sel);
			end
			default: ;
		endcase
	end

	// Hold strobe time and line drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= STROBE_RESET;
			lines_q  <= 1'b0;
		end else begin
			if (cfg_we)
				strobe_q <= cfg_wdata;
			if (ctl.emit && ctl.kind == KIND_POWER)
				lines_q <= 1'b1;
			else if (ctl.emit && ctl.kind == KIND_RELEASE)
				lines_q <= 1'b0;
		end
	end

	// Latch the byte of an accepted request
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= item_byte;
			rs_q   <= (in_data.cmd == CMD_DATA);
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit)
			out_q <= res;
	end

endmodule

// File: src/char_lcd_4bit_write_sequencer.sv
// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_stall   in_data   (cmd, value, column, line)
// out       out  out_valid/out_stall out_data  (rs, E, D7..D4, drive, hold, last)
// cfg       in   cfg_we              cfg_wdata (strobe_us)
//
// One pin state per cycle while the output register is free; an init request
// gives 25 states, a byte 4, off 5.
// The step sequencer handles one request at a time; in_stall is high while it runs.
// Reset (arst_n low) sets strobe_us to 50 and leaves the lines undriven.
// A stalled output holds the sequencer on its current step.
module char_lcd_4bit_write_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lcdw_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output lcdw_pkg::out_t   out_data,
	input  logic             cfg_we,
	input  logic [9:0]       cfg_wdata
);
	import lcdw_pkg::*;

	ctl_t ctl;
	sts_t sts;

	lcdw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	lcdw_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// A known operation locks out further requests
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.cmd <= CMD_OFF) |=> in_stall)
		else $error("sequencer not busy after accepting an operation");

	// The final pin state of a request never has E high
	a_last_e_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.enable_pin) |-> !out_data.last)
		else $error("last pin state has enable high");

	// Busy only starts from an accepted request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("busy without a request");
`endif

endmodule

// File: dv/char_lcd_4bit_write_sequencer_test.sv
`timescale 1ns / 100ps

module char_lcd_4bit_write_sequencer_test;
	import lcdw_pkg::*;

	localparam int RESET_CYCLES   = 4;
	localparam int SETTLE_CYCLES  = 40;
	localparam int IDLE_LIMIT     = 2000;
	localparam int PHASE_REQUESTS = 60;
	localparam int PHASE_COUNT    = 5;
	localparam int REPORT_MAX     = 10;
	localparam int HOLD_CEIL      = 16383;

	// Extra settle times added to the final E-low hold
	localparam int WAKE1_WAIT_US = 4000;
	localparam int WAKE2_WAIT_US = 100;
	localparam int WAKE3_WAIT_US = 1000;
	localparam int MODE_WAIT_US  = 1000;
	localparam int CLEAR_WAIT_US = 2000;

	localparam logic [7:0] SET_DDRAM  = 8'h80;
	localparam logic [7:0] LINE1_BASE = 8'h40;

	// Command codes the block must ignore
	localparam logic [2:0] CMD_UNUSED_A = CMD_OFF + 3'd1;
	localparam logic [2:0] CMD_UNUSED_B = CMD_OFF + 3'd2;

	localparam logic [9:0] STROBE_MIN = 10'd0;
	localparam logic [9:0] STROBE_MAX = 10'h3FF;

	// Predicts the pin states of each request and checks them in order
	class pin_state_scoreboard;
		logic [9:0] strobe_us;
		bit         rs_level;
		bit         lines_driven;
		out_t       pending_pins[$];
		out_t       held_pin;
		bit         have_held;
		int         errors;
		int         reported;

		function new();
			strobe_us    = STROBE_RESET;
			rs_level     = 1'b0;
			lines_driven = 1'b0;
			have_held    = 1'b0;
			errors       = 0;
			reported     = 0;
		endfunction

		// Hold back one state so the final one of a request can be flagged
		function void stage_pin(bit rs, bit en, logic [3:0] nib, bit drv, int hold);
			if (have_held)
				pending_pins.push_back(held_pin);
			if (hold > HOLD_CEIL)
				hold = HOLD_CEIL;
			held_pin.rs_pin      = rs;
			held_pin.enable_pin  = en;
			held_pin.data_nibble = nib;
			held_pin.drive_on    = drv;
			held_pin.hold_us     = 14'(hold);
			held_pin.last        = 1'b0;
			have_held            = 1'b1;
		endfunction

		function void stage_nibble(logic [3:0] nib, int extra);
			stage_pin(rs_level, 1'b1, nib, lines_driven, int'(strobe_us));
			stage_pin(rs_level, 1'b0, nib, lines_driven, int'(strobe_us) + extra);
		endfunction

		// High nibble first, extra wait on the low nibble only
		function void stage_byte(logic [7:0] b, bit rs, int extra);
			rs_level = rs;
			stage_nibble(b[7:4], 0);
			stage_nibble(b[3:0], extra);
		endfunction

		function void note_request(in_t r);
			case (r.cmd)
				CMD_INIT: begin
					lines_driven = 1'b1;
					rs_level     = 1'b0;
					stage_pin(1'b0, 1'b0, 4'h0, 1'b1, int'(POWER_HOLD_US));
					stage_nibble(NIB_WAKE, WAKE1_WAIT_US);
					stage_nibble(NIB_WAKE, WAKE2_WAIT_US);
					stage_nibble(NIB_WAKE, WAKE3_WAIT_US);
					stage_nibble(NIB_FOUR_BIT, MODE_WAIT_US);
					stage_byte(BYTE_FUNC, 1'b0, 0);
					stage_byte(BYTE_DISP_ON, 1'b0, 0);
					stage_byte(BYTE_ENTRY, 1'b0, 0);
					stage_byte(BYTE_CLEAR, 1'b0, CLEAR_WAIT_US);
				end
				CMD_INSTR: stage_byte(r.value, 1'b0, 0);
				CMD_DATA:  stage_byte(r.value, 1'b1, 0);
				CMD_POS: begin
					stage_byte(SET_DDRAM | ((r.line ? LINE1_BASE : 8'h00) + 8'(r.column)),
						1'b0, 0);
				end
				CMD_CLEAR: stage_byte(BYTE_CLEAR, 1'b0, CLEAR_WAIT_US);
				CMD_OFF: begin
					stage_byte(BYTE_DISP_OFF, 1'b0, 0);
					rs_level     = 1'b0;
					lines_driven = 1'b0;
					stage_pin(1'b0, 1'b0, 4'h0, 1'b0, 0);
				end
				default: ;
			endcase
			if (have_held) begin
				held_pin.last = 1'b1;
				pending_pins.push_back(held_pin);
				have_held = 1'b0;
			end
		endfunction

		function string pin_text(out_t p);
			return $sformatf("rs=%0d e=%0d d=%h drv=%0d hold=%0d last=%0d",
				p.rs_pin, p.enable_pin, p.data_nibble, p.drive_on, p.hold_us, p.last);
		endfunction

		function void check_pin_state(out_t got);
			out_t want;
			if (pending_pins.size() == 0) begin
				errors++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("unexpected pin state: %s", pin_text(got));
				end
				return;
			end
			want = pending_pins.pop_front();
			if (got.rs_pin !== want.rs_pin || got.enable_pin !== want.enable_pin ||
				got.data_nibble !== want.data_nibble || got.drive_on !== want.drive_on ||
				got.hold_us !== want.hold_us || got.last !== want.last) begin
				errors++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("pin state mismatch: expected %s, got %s",
						pin_text(want), pin_text(got));
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_t        in_data;
	logic       out_valid;
	logic       out_stall;
	out_t       out_data;
	logic       cfg_we;
	logic [9:0] cfg_wdata;

	pin_state_scoreboard sb;
	int gap_pct      = 0;
	int stall_pct    = 0;
	int quiet_cycles = 0;

	char_lcd_4bit_write_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// Track accepted requests and pin states; stop if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(in_data);
			if (out_valid && !out_stall)
				sb.check_pin_state(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("[char_lcd_4bit_write_sequencer] ERROR");
				$finish;
			end
		end
	end

	function automatic in_t make_request(logic [2:0] cmd, logic [7:0] value,
		logic [5:0] column, logic line);
		in_t r;
		r.cmd    = cmd;
		r.value  = value;
		r.column = column;
		r.line   = line;
		return r;
	endfunction

	// Mostly byte and position traffic, a few inits, offs and ignored codes
	function automatic in_t random_request();
		in_t r;
		int  pick;
		pick     = $urandom_range(99);
		r.value  = 8'($urandom);
		r.column = 6'($urandom_range(63));
		r.line   = 1'($urandom_range(1));
		if (pick < 5)
			r.cmd = CMD_INIT;
		else if (pick < 12)
			r.cmd = CMD_OFF;
		else if (pick < 17)
			r.cmd = $urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B;
		else if (pick < 27)
			r.cmd = CMD_CLEAR;
		else if (pick < 55)
			r.cmd = CMD_DATA;
		else if (pick < 75)
			r.cmd = CMD_INSTR;
		else
			r.cmd = CMD_POS;
		return r;
	endfunction

	// Present one request, with random gaps, and hold it until taken
	task automatic send_request(in_t r);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = r;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drop valid, wait for every pin state, then let the block go quiet
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_pins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_strobe(logic [9:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we       = 1'b0;
		sb.strobe_us = v;
	endtask

	initial begin
		in_t        req;
		int         sent;
		logic [9:0] strobe;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		sb        = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed: bytes on undriven lines, ignored codes, init, every operation,
		// position extremes on both lines, off and bytes after off
		send_request(make_request(CMD_INSTR, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_DATA, 8'hFF, 6'd63, 1'b1));
		send_request(make_request(CMD_POS, 8'h00, 6'd63, 1'b1));
		send_request(make_request(CMD_UNUSED_A, 8'hFF, 6'd63, 1'b1));
		send_request(make_request(CMD_UNUSED_B, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_INIT, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_INSTR, 8'hA5, 6'd21, 1'b0));
		send_request(make_request(CMD_INSTR, 8'hFF, 6'd0, 1'b0));
		send_request(make_request(CMD_DATA, 8'h5A, 6'd42, 1'b1));
		send_request(make_request(CMD_DATA, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_POS, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_POS, 8'h00, 6'd63, 1'b0));
		send_request(make_request(CMD_POS, 8'h00, 6'd0, 1'b1));
		send_request(make_request(CMD_POS, 8'hFF, 6'd63, 1'b1));
		send_request(make_request(CMD_CLEAR, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_OFF, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_DATA, 8'hC3, 6'd5, 1'b0));
		send_request(make_request(CMD_CLEAR, 8'h00, 6'd0, 1'b0));
		send_request(make_request(CMD_OFF, 8'hFF, 6'd63, 1'b1));
		send_request(make_request(CMD_INIT, 8'hFF, 6'd63, 1'b1));
		send_request(make_request(CMD_DATA, 8'h3C, 6'd9, 1'b1));
		drain();

		// Random phases, each with its own strobe and idling mix
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin strobe = STROBE_MAX; gap_pct = 0;  stall_pct = 0;  end
				1: begin strobe = STROBE_MIN; gap_pct = 64; stall_pct = 0;  end
				2: begin strobe = 10'd1;      gap_pct = 0;  stall_pct = 64; end
				3: begin strobe = 10'd1000;   gap_pct = 34; stall_pct = 34; end
				default: begin
					strobe    = 10'($urandom);
					gap_pct   = 64;
					stall_pct = 64;
				end
			endcase
			write_strobe(strobe);
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				req = random_request();
				send_request(req);
				if (req.cmd <= CMD_OFF)
					sent++;
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_pins.size() == 0)
			$display("[char_lcd_4bit_write_sequencer] OK");
		else
			$display("[char_lcd_4bit_write_sequencer] ERROR");
		$finish;
	end

endmodule

// File: files.f
src/lcdw_pkg.sv
src/lcdw_ctrl.sv
src/lcdw_dpath.sv
src/char_lcd_4bit_write_sequencer.sv
dv/char_lcd_4bit_write_sequencer_test.sv
